// ----- sv/cdate_pkg.sv -----
// shared types, constants and calendar helpers for the date add/subtract block
package cdate_pkg;

  // widths of the held year and of the day count
  localparam int YEAR_BITS  = 16;
  localparam int COUNT_BITS = 16;

  // leap rule constants; a year that is a multiple of 4 is a century year
  // exactly when it is also a multiple of CENTURY / 4
  localparam int LEAP_STEP = 4;
  localparam int CENTURY   = 100;
  localparam int QUAD_CENT = 400;
  localparam int RES_MOD   = CENTURY / LEAP_STEP;
  localparam int RES_W     = $clog2(RES_MOD);
  localparam int QUAD_BITS = $clog2(QUAD_CENT / RES_MOD);
  localparam int STEP_BITS = $clog2(LEAP_STEP);

  // reciprocal of RES_MOD: floor(y / RES_MOD) is (y * RECIP_MUL) >> RECIP_SHIFT
  // for every year value that fits in YEAR_BITS
  localparam int RECIP_SHIFT = YEAR_BITS + $clog2(RES_MOD);
  localparam int RECIP_W     = YEAR_BITS + 1;
  localparam longint unsigned RECIP_MUL =
    ((64'd1 << RECIP_SHIFT) + RES_MOD - 1) / RES_MOD;

  localparam int MONTHS    = 12;
  localparam int FEB       = 2;
  localparam int FEB_DAYS  = 28;
  localparam int LEAP_DAYS = 29;

  localparam logic [YEAR_BITS-1:0] YEAR_MAX = '1;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_ADD  = 2'd1,
    OP_SUB  = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2
  } stat_t;

  // one date plus the year modulo RES_MOD that the leap rule needs
  typedef struct packed {
    logic [4:0]           day;
    logic [3:0]           month;
    logic [YEAR_BITS-1:0] year;
    logic [RES_W-1:0]     res;
  } date_t;

  // outcome of one month step
  typedef struct packed {
    logic done;
    logic fail;
  } step_res_t;

  // leap year from the low year bits and the year modulo RES_MOD
  function automatic logic is_leap(input logic [QUAD_BITS-1:0] ylow,
                                   input logic [RES_W-1:0] res);
    logic quad;
    logic quad_cent;
    quad      = (ylow[STEP_BITS-1:0] == '0);
    quad_cent = (ylow == '0);
    return quad && ((res != '0) || quad_cent);
  endfunction

  // days in a month; codes outside 1..12 give 31
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:    len = leap ? 5'(LEAP_DAYS) : 5'(FEB_DAYS);
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- sv/cdate_mod25.sv -----
// year remainder unit for the century part of the leap rule, by reciprocal multiply
module cdate_mod25 (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [cdate_pkg::YEAR_BITS-1:0]   value,
  output logic                              busy,
  output logic [cdate_pkg::RES_W-1:0]       rem
);

  localparam int YW = cdate_pkg::YEAR_BITS;
  localparam int MW = cdate_pkg::RECIP_W;
  localparam int PW = YW + MW;
  localparam int QW = PW - cdate_pkg::RECIP_SHIFT;
  localparam logic [MW-1:0] MUL_K = MW'(cdate_pkg::RECIP_MUL);
  localparam logic [YW-1:0] MOD_K = YW'(cdate_pkg::RES_MOD);

  logic                             busy_r, busy_nxt;
  logic [YW-1:0]                    val_r, val_nxt;
  logic [QW-1:0]                    quo_r, quo_nxt;
  logic [cdate_pkg::RES_W-1:0]      rem_r, rem_nxt;
  logic [PW-1:0]                    prod;
  logic [YW-1:0]                    back;
  logic [YW-1:0]                    diff;

  // first step: quotient from the reciprocal product
  assign prod = {{MW{1'b0}}, value} * {{YW{1'b0}}, MUL_K};

  // second step: remainder is the year minus quotient times the modulus
  assign back = {{(YW-QW){1'b0}}, quo_r} * MOD_K;
  assign diff = val_r - back;

  always_comb begin
    busy_nxt = busy_r;
    val_nxt  = val_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      val_nxt  = value;
      quo_nxt  = prod[PW-1:cdate_pkg::RECIP_SHIFT];
    end else if (busy_r) begin
      rem_nxt  = cdate_pkg::RES_W'(diff);
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    val_r <= val_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign rem  = rem_r;

endmodule

// ----- sv/cdate_step.sv -----
// one month of the date walk: shared count subtractor plus month and year carry
module cdate_step (
  input  cdate_pkg::date_t                  cur,
  input  logic                              dir_sub,
  input  logic [cdate_pkg::COUNT_BITS-1:0]  cnt,
  output cdate_pkg::date_t                  nxt,
  output logic [cdate_pkg::COUNT_BITS-1:0]  cnt_nxt,
  output cdate_pkg::step_res_t              res
);

  localparam int CW = cdate_pkg::COUNT_BITS;

  logic                 leap_cur;
  logic                 leap_new;
  logic [4:0]           mlen_cur;
  logic [5:0]           rem_fwd;
  logic [5:0]           opnd;
  logic [CW:0]          diff;
  logic                 borrow;
  logic [3:0]           month_b;
  logic [cdate_pkg::YEAR_BITS-1:0] year_b;
  logic [cdate_pkg::RES_W-1:0]     res_b;

  // days left in the current month, counting the current day
  assign leap_cur = cdate_pkg::is_leap(cur.year[cdate_pkg::QUAD_BITS-1:0], cur.res);
  assign mlen_cur = cdate_pkg::month_len(cur.month, leap_cur);
  assign rem_fwd  = {1'b0, mlen_cur} - {1'b0, cur.day} + 6'd1;

  // shared subtractor: count minus days consumed by this month
  assign opnd   = dir_sub ? {1'b0, cur.day} : rem_fwd;
  assign diff   = {1'b0, cnt} - (CW + 1)'(opnd);
  assign borrow = diff[CW];

  // previous month and year for the backward walk
  always_comb begin
    month_b = cur.month - 4'd1;
    year_b  = cur.year;
    res_b   = cur.res;
    if (cur.month <= 4'd1) begin
      month_b = 4'(cdate_pkg::MONTHS);
      year_b  = cur.year - 1'b1;
      if (cur.res == '0) begin
        res_b = cdate_pkg::RES_W'(cdate_pkg::RES_MOD - 1);
      end else begin
        res_b = cur.res - 1'b1;
      end
    end
  end

  assign leap_new = cdate_pkg::is_leap(year_b[cdate_pkg::QUAD_BITS-1:0], res_b);

  always_comb begin
    nxt      = cur;
    cnt_nxt  = diff[CW-1:0];
    res.done = 1'b0;
    res.fail = 1'b0;
    if (borrow) begin
      // count ends inside this month
      res.done = 1'b1;
      cnt_nxt  = '0;
      if (dir_sub) begin
        nxt.day = cur.day - cnt[4:0];
      end else begin
        nxt.day = cur.day + cnt[4:0];
      end
    end else if (!dir_sub) begin
      // forward to the first of the next month
      nxt.day = 5'd1;
      if (cur.month >= 4'(cdate_pkg::MONTHS)) begin
        nxt.month = 4'd1;
        if (cur.year == cdate_pkg::YEAR_MAX) begin
          res.fail = 1'b1;
        end
        nxt.year = cur.year + 1'b1;
        if (cur.res == cdate_pkg::RES_W'(cdate_pkg::RES_MOD - 1)) begin
          nxt.res = '0;
        end else begin
          nxt.res = cur.res + 1'b1;
        end
      end else begin
        nxt.month = cur.month + 4'd1;
      end
    end else begin
      // back to the last day of the previous month
      nxt.month = month_b;
      nxt.year  = year_b;
      nxt.res   = res_b;
      nxt.day   = cdate_pkg::month_len(month_b, leap_new);
      if (cur.month <= 4'd1 && cur.year == '0) begin
        res.fail = 1'b1;
      end
    end
  end

endmodule

// ----- sv/calendar_date_add_subtract.sv -----
// Gregorian date register with set, add days, subtract days and read, one
// result beat per input beat. A read passes straight to the result register.
// A set first reduces the year modulo 25 for the century leap check by a
// reciprocal multiply and a multiply-back, then the day is checked against the
// month length. Add and subtract walk the date one month per cycle through a
// shared subtractor. The input is ready again the cycle after the result
// register is loaded; a finished result waits in the output register while the
// next input beat is taken, and a result still waiting there when the next one
// is done holds the block until it is taken.
module calendar_date_add_subtract (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_opcode,
  input  logic [4:0]                        in_set_day,
  input  logic [3:0]                        in_set_month,
  input  logic [15:0]                       in_set_year,
  input  logic [15:0]                       in_day_count,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [4:0]                        out_cur_day,
  output logic [3:0]                        out_cur_month,
  output logic [15:0]                       out_cur_year,
  output logic [1:0]                        out_status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_WALK,
    S_FIN
  } state_t;

  state_t                                   state_r, state_nxt;
  cdate_pkg::op_t                           op_r, op_nxt;
  cdate_pkg::stat_t                         stat_r, stat_nxt;
  cdate_pkg::date_t                         cur_r, cur_nxt;
  cdate_pkg::date_t                         wrk_r, wrk_nxt;
  logic [cdate_pkg::COUNT_BITS-1:0]         cnt_r, cnt_nxt;
  logic [4:0]                               sday_r, sday_nxt;
  logic [3:0]                               smonth_r, smonth_nxt;
  logic [cdate_pkg::YEAR_BITS-1:0]          syear_r, syear_nxt;
  logic                                     out_valid_r, out_valid_nxt;
  logic [4:0]                               oday_r, oday_nxt;
  logic [3:0]                               omonth_r, omonth_nxt;
  logic [15:0]                              oyear_r, oyear_nxt;
  logic [1:0]                               ostat_r, ostat_nxt;

  logic                                     in_fire;
  logic                                     mod_start;
  logic                                     mod_busy;
  logic [cdate_pkg::RES_W-1:0]              mod_rem;
  cdate_pkg::date_t                         step_nxt;
  logic [cdate_pkg::COUNT_BITS-1:0]         step_cnt;
  cdate_pkg::step_res_t                     step_res;
  logic                                     set_leap;
  logic [4:0]                               set_mlen;
  logic                                     set_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign mod_start = in_fire && (cdate_pkg::op_t'(in_opcode) == cdate_pkg::OP_SET);

  // year remainder for the set check
  cdate_mod25 u_mod25 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .value (cdate_pkg::YEAR_BITS'(in_set_year)),
    .busy  (mod_busy),
    .rem   (mod_rem)
  );

  // month step unit
  cdate_step u_step (
    .cur     (wrk_r),
    .dir_sub (op_r == cdate_pkg::OP_SUB),
    .cnt     (cnt_r),
    .nxt     (step_nxt),
    .cnt_nxt (step_cnt),
    .res     (step_res)
  );

  // set date check against the month length
  assign set_leap = cdate_pkg::is_leap(syear_r[cdate_pkg::QUAD_BITS-1:0], mod_rem);
  assign set_mlen = cdate_pkg::month_len(smonth_r, set_leap);
  assign set_ok   = (smonth_r >= 4'd1) && (smonth_r <= 4'(cdate_pkg::MONTHS)) &&
                    (sday_r != 5'd0) && (sday_r <= set_mlen);

  // sequencer and result register
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    stat_nxt      = stat_r;
    cur_nxt       = cur_r;
    wrk_nxt       = wrk_r;
    cnt_nxt       = cnt_r;
    sday_nxt      = sday_r;
    smonth_nxt    = smonth_r;
    syear_nxt     = syear_r;
    out_valid_nxt = out_valid_r;
    oday_nxt      = oday_r;
    omonth_nxt    = omonth_r;
    oyear_nxt     = oyear_r;
    ostat_nxt     = ostat_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt     = cdate_pkg::op_t'(in_opcode);
          stat_nxt   = cdate_pkg::ST_OK;
          sday_nxt   = in_set_day;
          smonth_nxt = in_set_month;
          syear_nxt  = cdate_pkg::YEAR_BITS'(in_set_year);
          cnt_nxt    = cdate_pkg::COUNT_BITS'(in_day_count);
          wrk_nxt    = cur_r;
          case (cdate_pkg::op_t'(in_opcode))
            cdate_pkg::OP_SET:  state_nxt = S_MOD;
            cdate_pkg::OP_ADD:  state_nxt = S_WALK;
            cdate_pkg::OP_SUB:  state_nxt = S_WALK;
            default:            state_nxt = S_FIN;
          endcase
        end
      end
      S_MOD: begin
        if (!mod_busy) begin
          if (set_ok) begin
            cur_nxt.day   = sday_r;
            cur_nxt.month = smonth_r;
            cur_nxt.year  = syear_r;
            cur_nxt.res   = mod_rem;
          end else begin
            stat_nxt = cdate_pkg::ST_INVALID;
          end
          state_nxt = S_FIN;
        end
      end
      S_WALK: begin
        if (step_res.fail) begin
          stat_nxt  = cdate_pkg::ST_RANGE;
          state_nxt = S_FIN;
        end else if (step_res.done) begin
          cur_nxt   = step_nxt;
          state_nxt = S_FIN;
        end else begin
          wrk_nxt = step_nxt;
          cnt_nxt = step_cnt;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          oday_nxt      = cur_r.day;
          omonth_nxt    = cur_r.month;
          oyear_nxt     = 16'(cur_r.year);
          ostat_nxt     = stat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      cur_r.day     <= 5'd1;
      cur_r.month   <= 4'd1;
      cur_r.year    <= '0;
      cur_r.res     <= '0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      cur_r         <= cur_nxt;
    end
    op_r     <= op_nxt;
    stat_r   <= stat_nxt;
    wrk_r    <= wrk_nxt;
    cnt_r    <= cnt_nxt;
    sday_r   <= sday_nxt;
    smonth_r <= smonth_nxt;
    syear_r  <= syear_nxt;
    oday_r   <= oday_nxt;
    omonth_r <= omonth_nxt;
    oyear_r  <= oyear_nxt;
    ostat_r  <= ostat_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_cur_day   = oday_r;
  assign out_cur_month = omonth_r;
  assign out_cur_year  = oyear_r;
  assign out_status    = ostat_r;

  // held date is always a real calendar date
  ast_cur_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_r.month >= 4'd1) && (cur_r.month <= 4'(cdate_pkg::MONTHS)) &&
    (cur_r.day >= 5'd1) &&
    (cur_r.day <= cdate_pkg::month_len(cur_r.month,
      cdate_pkg::is_leap(cur_r.year[cdate_pkg::QUAD_BITS-1:0], cur_r.res))))
    else $error("held date out of range");

  // a walk past the year range keeps the held date
  ast_range_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) && step_res.fail |=>
      (cur_r == $past(cur_r)) && (stat_r == cdate_pkg::ST_RANGE))
    else $error("range failure changed the date");

  // year remainder stays below its modulus
  ast_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r.res < cdate_pkg::RES_W'(cdate_pkg::RES_MOD))
    else $error("year remainder out of range");

  // one beat in progress at a time
  ast_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("input taken while busy");

endmodule

// ----- bench/calendar_date_add_subtract_checker.sv -----
// result checker for the date block: tracks the date, predicts each result beat and compares
`timescale 1ns / 1ps
module calendar_date_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [4:0]  in_set_day,
  input  logic [3:0]  in_set_month,
  input  logic [15:0] in_set_year,
  input  logic [15:0] in_day_count,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [4:0]  out_cur_day,
  input  logic [3:0]  out_cur_month,
  input  logic [15:0] out_cur_year,
  input  logic [1:0]  out_status,
  output int          pending,
  output int          errors,
  output int          checked,
  output int          rejected_sets,
  output int          range_faults
);

  localparam int SHOWN_FAULTS = 10;
  localparam int YB           = cdate_pkg::YEAR_BITS;
  localparam int CB           = cdate_pkg::COUNT_BITS;

  typedef struct packed {
    logic [4:0]       day;
    logic [3:0]       month;
    logic [YB-1:0]    year;
    cdate_pkg::stat_t status;
  } date_reply_t;

  // dates still owed by the block, oldest first
  date_reply_t owed_q[$];

  // predicted date register
  logic [4:0]    cal_day;
  logic [3:0]    cal_month;
  logic [YB-1:0] cal_year;

  // gregorian rule: every 4th year, except centuries not divisible by 400
  function automatic logic leap_year(input logic [YB-1:0] y);
    int unsigned yi;
    yi = y;
    return ((yi % cdate_pkg::LEAP_STEP) == 0 && (yi % cdate_pkg::CENTURY) != 0) ||
           (yi % cdate_pkg::QUAD_CENT) == 0;
  endfunction

  function automatic logic [4:0] days_in_month(input logic [3:0] m,
                                               input logic [YB-1:0] y);
    case (m)
      4'(cdate_pkg::FEB):
        return leap_year(y) ? 5'(cdate_pkg::LEAP_DAYS) : 5'(cdate_pkg::FEB_DAYS);
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default:                return 5'd31;
    endcase
  endfunction

  // apply one input beat to the predicted date and return the result it owes
  function automatic date_reply_t apply_item(input cdate_pkg::op_t op,
                                             input logic [4:0] sd,
                                             input logic [3:0] sm,
                                             input logic [YB-1:0] sy,
                                             input logic [CB-1:0] cnt);
    date_reply_t   r;
    int unsigned   left;
    int unsigned   room;
    logic [4:0]    d;
    logic [3:0]    m;
    logic [YB-1:0] y;
    logic          ok;
    d = cal_day;
    m = cal_month;
    y = cal_year;
    ok = 1'b1;
    left = cnt;
    r.status = cdate_pkg::ST_OK;
    case (op)
      cdate_pkg::OP_SET: begin
        if (sm < 1 || sm > cdate_pkg::MONTHS || sd < 1 ||
            sd > days_in_month(sm, sy)) begin
          r.status = cdate_pkg::ST_INVALID;
        end else begin
          d = sd;
          m = sm;
          y = sy;
        end
      end
      // forward walk: finish the current month, then carry into the next
      cdate_pkg::OP_ADD: begin
        while (ok && left != 0) begin
          room = days_in_month(m, y) - d + 1;
          if (left < room) begin
            d = d + 5'(left);
            left = 0;
          end else begin
            left = left - room;
            d = 5'd1;
            if (m == cdate_pkg::MONTHS) begin
              m = 4'd1;
              if (y == cdate_pkg::YEAR_MAX) ok = 1'b0;
              else y = y + 1'b1;
            end else begin
              m = m + 1'b1;
            end
          end
        end
      end
      // backward walk: drop to the last day of the previous month
      cdate_pkg::OP_SUB: begin
        while (ok && left != 0) begin
          if (left < d) begin
            d = d - 5'(left);
            left = 0;
          end else begin
            left = left - d;
            if (m <= 1) begin
              m = 4'(cdate_pkg::MONTHS);
              if (y == 0) ok = 1'b0;
              else y = y - 1'b1;
            end else begin
              m = m - 1'b1;
            end
            d = days_in_month(m, y);
          end
        end
      end
      default: ;
    endcase
    // a walk that leaves the year range keeps the old date
    if (!ok) begin
      r.status = cdate_pkg::ST_RANGE;
    end else begin
      cal_day = d;
      cal_month = m;
      cal_year = y;
    end
    r.day = cal_day;
    r.month = cal_month;
    r.year = cal_year;
    return r;
  endfunction

  task automatic report_fault(input string what);
    errors++;
    if (errors <= SHOWN_FAULTS) $display("%0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin : watch
    date_reply_t want;
    if (!rst_n) begin
      cal_day = 5'd1;
      cal_month = 4'd1;
      cal_year = '0;
      owed_q.delete();
      errors = 0;
      checked = 0;
      rejected_sets = 0;
      range_faults = 0;
      pending <= 0;
    end else begin
      // result beat against the oldest owed date
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          report_fault($sformatf("result beat %0d/%0d/%0d st %0d with nothing owed",
                                 out_cur_day, out_cur_month, out_cur_year, out_status));
        end else begin
          want = owed_q.pop_front();
          checked++;
          if (out_cur_day !== want.day || out_cur_month !== want.month ||
              out_cur_year !== want.year || out_status !== want.status) begin
            report_fault($sformatf(
              "date mismatch: want %0d/%0d/%0d st %0d, got %0d/%0d/%0d st %0d",
              want.day, want.month, want.year, want.status,
              out_cur_day, out_cur_month, out_cur_year, out_status));
          end
        end
      end
      // input beat updates the predicted date
      if (in_valid && in_ready) begin
        want = apply_item(cdate_pkg::op_t'(in_opcode), in_set_day, in_set_month,
                          in_set_year, in_day_count);
        if (want.status == cdate_pkg::ST_INVALID) rejected_sets++;
        if (want.status == cdate_pkg::ST_RANGE) range_faults++;
        owed_q.push_back(want);
      end
      pending <= owed_q.size();
    end
  end

endmodule

// ----- bench/calendar_date_add_subtract_tb.sv -----
// testbench top for the date block: clock, reset, stimulus, back-pressure and verdict
`timescale 1ns / 1ps
module calendar_date_add_subtract_tb;

  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 250;
  localparam int CALM_ITEMS   = 40;
  localparam int HOLD_AT      = 80;
  localparam int PAUSE_AT     = 150;
  localparam int LONG_HOLD    = 300;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 3_000_000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_opcode;
  logic [4:0]  in_set_day;
  logic [3:0]  in_set_month;
  logic [15:0] in_set_year;
  logic [15:0] in_day_count;
  logic        out_valid;
  logic        out_ready;
  logic [4:0]  out_cur_day;
  logic [3:0]  out_cur_month;
  logic [15:0] out_cur_year;
  logic [1:0]  out_status;

  int pending;
  int errors;
  int checked;
  int rejected_sets;
  int range_faults;

  int cycles = 0;
  int sets = 0;
  int adds = 0;
  int subs = 0;
  int reads = 0;
  logic calm = 1'b0;
  logic hold_req = 1'b0;

  calendar_date_add_subtract dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_set_day    (in_set_day),
    .in_set_month  (in_set_month),
    .in_set_year   (in_set_year),
    .in_day_count  (in_day_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cur_day   (out_cur_day),
    .out_cur_month (out_cur_month),
    .out_cur_year  (out_cur_year),
    .out_status    (out_status)
  );

  calendar_date_checker date_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_set_day    (in_set_day),
    .in_set_month  (in_set_month),
    .in_set_year   (in_set_year),
    .in_day_count  (in_day_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cur_day   (out_cur_day),
    .out_cur_month (out_cur_month),
    .out_cur_year  (out_cur_year),
    .out_status    (out_status),
    .pending       (pending),
    .errors        (errors),
    .checked       (checked),
    .rejected_sets (rejected_sets),
    .range_faults  (range_faults)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d results owed", cycles, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold-off, none in the calm tail
  initial begin : receiver
    logic hold_served;
    hold_served = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 99) < 20) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // offer one beat, maybe after an idle burst, and wait until it is taken
  task automatic offer_item(input cdate_pkg::op_t op, input logic [4:0] sd,
                            input logic [3:0] sm, input logic [15:0] sy,
                            input logic [15:0] cnt);
    int gap;
    if (!calm && $urandom_range(0, 99) < 25) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_set_day   <= sd;
    in_set_month <= sm;
    in_set_year  <= sy;
    in_day_count <= cnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (op)
      cdate_pkg::OP_SET:  sets++;
      cdate_pkg::OP_ADD:  adds++;
      cdate_pkg::OP_SUB:  subs++;
      default:            reads++;
    endcase
  endtask

  // stop offering until every owed result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    cdate_pkg::op_t op;
    logic [4:0]     sd;
    logic [3:0]     sm;
    logic [15:0]    sy;
    logic [15:0]    cnt;
    int             roll;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_opcode    <= cdate_pkg::OP_READ;
    in_set_day   <= '0;
    in_set_month <= '0;
    in_set_year  <= '0;
    in_day_count <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset date, zero counts, year 0 underflow and leap february
    offer_item(cdate_pkg::OP_READ, 5'($urandom), 4'($urandom), 16'($urandom),
               16'($urandom));
    offer_item(cdate_pkg::OP_SUB, 5'd0, 4'd0, 16'd0, 16'd1);
    offer_item(cdate_pkg::OP_ADD, 5'd0, 4'd0, 16'd0, 16'd0);
    offer_item(cdate_pkg::OP_SUB, 5'd0, 4'd0, 16'd0, 16'd0);
    offer_item(cdate_pkg::OP_ADD, 5'd0, 4'd0, 16'd0, 16'd59);
    // rejected sets: bad months, day zero, day past month end, non-leap century
    offer_item(cdate_pkg::OP_SET, 5'd5, 4'd0, 16'd2024, 16'd0);
    offer_item(cdate_pkg::OP_SET, 5'd5, 4'd13, 16'd2024, 16'd0);
    offer_item(cdate_pkg::OP_SET, 5'd31, 4'd15, 16'hFFFF, 16'hFFFF);
    offer_item(cdate_pkg::OP_SET, 5'd0, 4'd3, 16'd2024, 16'd0);
    offer_item(cdate_pkg::OP_SET, 5'd31, 4'd4, 16'd2023, 16'd0);
    offer_item(cdate_pkg::OP_SET, 5'd29, 4'd2, 16'd1900, 16'd0);
    offer_item(cdate_pkg::OP_SET, 5'd30, 4'd2, 16'd2024, 16'd0);
    // leap days that are accepted, and walks across them
    offer_item(cdate_pkg::OP_SET, 5'd29, 4'd2, 16'd2000, 16'd0);
    offer_item(cdate_pkg::OP_SET, 5'd29, 4'd2, 16'd2024, 16'($urandom));
    offer_item(cdate_pkg::OP_SUB, 5'd0, 4'd0, 16'd0, 16'd365);
    offer_item(cdate_pkg::OP_SET, 5'd28, 4'd2, 16'd2100, 16'd0);
    offer_item(cdate_pkg::OP_ADD, 5'd0, 4'd0, 16'd0, 16'd1);
    // top of the year range
    offer_item(cdate_pkg::OP_SET, 5'd31, 4'd12, 16'hFFFF, 16'd0);
    offer_item(cdate_pkg::OP_ADD, 5'd0, 4'd0, 16'd0, 16'd1);
    offer_item(cdate_pkg::OP_ADD, 5'd0, 4'd0, 16'd0, 16'hFFFF);
    offer_item(cdate_pkg::OP_SUB, 5'd0, 4'd0, 16'd0, 16'hFFFF);
    // bottom of the year range with the largest count
    offer_item(cdate_pkg::OP_SET, 5'd1, 4'd1, 16'd0, 16'd0);
    offer_item(cdate_pkg::OP_SUB, 5'd0, 4'd0, 16'd0, 16'hFFFF);
    offer_item(cdate_pkg::OP_ADD, 5'd0, 4'd0, 16'd0, 16'hFFFF);
    offer_item(cdate_pkg::OP_READ, 5'($urandom), 4'($urandom), 16'($urandom),
               16'($urandom));
    drain_results();

    // random: mostly valid dates and small counts, some raw fields and full counts
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i == PAUSE_AT) drain_results();
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      sd = 5'($urandom);
      sm = 4'($urandom);
      sy = 16'($urandom);
      cnt = 16'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 25) op = cdate_pkg::OP_SET;
      else if (roll < 55) op = cdate_pkg::OP_ADD;
      else if (roll < 85) op = cdate_pkg::OP_SUB;
      else op = cdate_pkg::OP_READ;
      if (op == cdate_pkg::OP_SET) begin
        if ($urandom_range(0, 9) != 0) sm = 4'($urandom_range(1, cdate_pkg::MONTHS));
        case ($urandom_range(0, 9))
          0:       ;  // raw day, zero included
          1:       sd = 5'($urandom_range(29, 31));
          default: sd = 5'($urandom_range(1, 28));
        endcase
        case ($urandom_range(0, 9))
          0, 1:    sy = 16'($urandom_range(0, 200));
          2:       sy = 16'($urandom_range(65335, 65535));
          3:       sy = 16'($urandom_range(0, 655) * cdate_pkg::CENTURY);
          default: ;
        endcase
      end else begin
        case ($urandom_range(0, 19))
          0:                cnt = '0;
          1:                cnt = '1;
          2, 3:             ;  // full 16-bit count
          4, 5, 6, 7, 8, 9: cnt = 16'($urandom_range(0, 4000));
          default:          cnt = 16'($urandom_range(0, 400));
        endcase
      end
      offer_item(op, sd, sm, sy, cnt);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d beats: %0d set, %0d add, %0d subtract, %0d read",
             sets + adds + subs + reads, sets, adds, subs, reads);
    $display("%0d results checked, %0d sets rejected, %0d walks kept the date, %0d faults",
             checked, rejected_sets, range_faults, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/cdate_pkg.sv
sv/cdate_mod25.sv
sv/cdate_step.sv
sv/calendar_date_add_subtract.sv
bench/calendar_date_add_subtract_checker.sv
bench/calendar_date_add_subtract_tb.sv
